[src/scp_pkg.sv]
// ----------------------------------------------------------------------------
// scp_pkg
// Shared types and constants for the stripe chunk planner.
// ----------------------------------------------------------------------------
package scp_pkg;

  // field widths
  localparam int OPCODE_W   = 2;
  localparam int ADDR_W     = 48;
  localparam int COUNT_W    = 32;
  localparam int KIND_W     = 2;
  localparam int VOL_W      = 4;
  localparam int BLK_W      = 17;
  localparam int NVOL_W     = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;

  // shared divider widths
  localparam int DVD_W = ADDR_W;
  localparam int DSR_W = BLK_W;

  localparam logic [OPCODE_W-1:0] OP_READ  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_WRITE = 2'd1;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_VOLUMES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE  = 1'b1;

  localparam logic [BLK_W-1:0]  DEFAULT_BLOCK   = 17'd8192;
  localparam logic [BLK_W-1:0]  BLOCK_LIMIT     = 17'd65536;
  localparam int                VOL_FIELD_LIMIT = 16;

  typedef enum logic [KIND_W-1:0] {
    KIND_SEEK = 2'd0,
    KIND_XFER = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DVD_W-1:0] quotient;
    logic [DSR_W-1:0] remainder;
  } div_rsp_t;

endpackage

[src/scp_div.sv]
// ----------------------------------------------------------------------------
// scp_div
// Restoring divider, one quotient bit per cycle, shared by both divide passes.
// ----------------------------------------------------------------------------
module scp_div (
  input  logic              clk,
  input  logic              rst_n,
  input  scp_pkg::div_req_t req,
  output scp_pkg::div_rsp_t rsp
);
  import scp_pkg::*;

  localparam int CNT_W = $clog2(DVD_W);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVD_W-1:0] dvd_r, dvd_nxt;
  logic [DSR_W-1:0] rem_r, rem_nxt;
  logic [DSR_W-1:0] dsr_r, dsr_nxt;

  logic [DSR_W:0]   trial;
  logic [DSR_W:0]   diff;
  logic             ge;

  assign trial = {rem_r, dvd_r[DVD_W-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign ge    = trial >= {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = req.dividend;
      dsr_nxt  = req.divisor;
      rem_nxt  = '0;
    end else if (busy_r) begin
      // quotient bits shift in where dividend bits shift out
      dvd_nxt = {dvd_r[DVD_W-2:0], ge};
      rem_nxt = ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DVD_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = dvd_r;
  assign rsp.remainder = rem_r;

endmodule

[src/stripe_chunk_planner.sv]
// ----------------------------------------------------------------------------
// stripe_chunk_planner
// Turns read/write requests on a round-robin striped file into per-volume
// seek commands and transfer chunks.
// ----------------------------------------------------------------------------
// From request accept to the first result: two 48-step divider passes, one
//   shift-add step per block size bit, then the prep and check states.
// Throughput: one request at a time; then one result per cycle while out_ready
//   is high. An illegal opcode gives its error result from the error state.
// Reset (synchronous): controller idle, num_volumes 1, block_size 8192,
//   expected next byte all ones, last operation read.
module stripe_chunk_planner #(
  parameter int MAX_VOLUMES = 16,
  parameter int MAX_CHUNKS  = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [scp_pkg::OPCODE_W-1:0]     in_opcode,
  input  logic [scp_pkg::ADDR_W-1:0]       in_first_byte,
  input  logic [scp_pkg::COUNT_W-1:0]      in_byte_count,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [scp_pkg::KIND_W-1:0]       out_kind,
  output logic [scp_pkg::VOL_W-1:0]        out_volume,
  output logic [scp_pkg::ADDR_W-1:0]       out_position,
  output logic [scp_pkg::BLK_W-1:0]        out_chunk_length,
  output logic [scp_pkg::COUNT_W-1:0]      out_buffer_offset,
  output logic                             out_is_write,
  output logic                             out_last,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [scp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [scp_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import scp_pkg::*;

  localparam int VOL_CAP_I = (MAX_VOLUMES < VOL_FIELD_LIMIT) ? MAX_VOLUMES : VOL_FIELD_LIMIT;
  localparam logic [NVOL_W-1:0] VOL_CAP = NVOL_W'(VOL_CAP_I);
  localparam int LIM_W = BLK_W + $clog2(MAX_CHUNKS + 1) + 1;
  localparam int CMP_W = (LIM_W > COUNT_W) ? LIM_W : COUNT_W;
  localparam logic [LIM_W-1:0] EXTRA_BLOCKS = LIM_W'(MAX_CHUNKS - 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV_BLK, ST_DIV_VOL, ST_MUL, ST_PREP, ST_CHECK, ST_SEEK, ST_CHUNK, ST_ERR
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [NVOL_W-1:0]   num_volumes_r;
  logic [BLK_W-1:0]    block_size_r;
  logic [NVOL_W-1:0]   n_eff;
  logic [BLK_W-1:0]    bs_eff;

  // persistent state
  logic [ADDR_W:0]     expected_next_r, expected_next_nxt;
  logic                prev_op_r, prev_op_nxt;

  // request and working registers
  logic [OPCODE_W-1:0] op_r, op_nxt;
  logic [ADDR_W-1:0]   first_r, first_nxt;
  logic [COUNT_W-1:0]  count_r, count_nxt;
  logic [BLK_W-1:0]    inblock_r, inblock_nxt;
  logic [VOL_W-1:0]    fullvol_r, fullvol_nxt;
  logic [ADDR_W-1:0]   mcand_r, mcand_nxt;
  logic [BLK_W-1:0]    mplier_r, mplier_nxt;
  logic [ADDR_W-1:0]   acc_r, acc_nxt;        // holds off2 once the multiply is done
  logic [ADDR_W-1:0]   off1_r, off1_nxt;
  logic [ADDR_W-1:0]   offm_r, offm_nxt;
  logic [BLK_W-1:0]    len0_r, len0_nxt;
  logic [LIM_W-1:0]    lim_r, lim_nxt;
  logic                need_seek_r, need_seek_nxt;
  logic [VOL_W-1:0]    seek_idx_r, seek_idx_nxt;
  logic [VOL_W-1:0]    cvol_r, cvol_nxt;
  logic [COUNT_W-1:0]  left_r, left_nxt;
  logic [COUNT_W-1:0]  boff_r, boff_nxt;
  logic [BLK_W-1:0]    len_r, len_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  kind_t               out_kind_r, out_kind_nxt;
  logic [VOL_W-1:0]    out_volume_r, out_volume_nxt;
  logic [ADDR_W-1:0]   out_position_r, out_position_nxt;
  logic [BLK_W-1:0]    out_len_r, out_len_nxt;
  logic [COUNT_W-1:0]  out_boff_r, out_boff_nxt;
  logic                out_wr_r, out_wr_nxt;
  logic                out_last_r, out_last_nxt;

  div_req_t            div_req;
  div_rsp_t            div_rsp;

  logic                slot_free;
  logic                seek_last;
  logic                chunk_last;
  logic [BLK_W-1:0]    clen;
  logic [BLK_W-1:0]    len0_calc;

  scp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_comb begin
    if (num_volumes_r == '0) n_eff = NVOL_W'(1);
    else if (num_volumes_r > VOL_CAP) n_eff = VOL_CAP;
    else n_eff = num_volumes_r;
  end

  always_comb begin
    if (block_size_r == '0) bs_eff = DEFAULT_BLOCK;
    else if (block_size_r > BLOCK_LIMIT) bs_eff = BLOCK_LIMIT;
    else bs_eff = block_size_r;
  end

  assign slot_free  = !out_valid_r || out_ready;
  assign seek_last  = (NVOL_W'(seek_idx_r) + NVOL_W'(1)) == n_eff;
  assign chunk_last = COUNT_W'(len_r) >= left_r;
  assign clen       = (COUNT_W'(len_r) > left_r) ? left_r[BLK_W-1:0] : len_r;
  assign len0_calc  = bs_eff - inblock_r;

  always_comb begin
    state_nxt         = state_r;
    expected_next_nxt = expected_next_r;
    prev_op_nxt       = prev_op_r;
    op_nxt            = op_r;
    first_nxt         = first_r;
    count_nxt         = count_r;
    inblock_nxt       = inblock_r;
    fullvol_nxt       = fullvol_r;
    mcand_nxt         = mcand_r;
    mplier_nxt        = mplier_r;
    acc_nxt           = acc_r;
    off1_nxt          = off1_r;
    offm_nxt          = offm_r;
    len0_nxt          = len0_r;
    lim_nxt           = lim_r;
    need_seek_nxt     = need_seek_r;
    seek_idx_nxt      = seek_idx_r;
    cvol_nxt          = cvol_r;
    left_nxt          = left_r;
    boff_nxt          = boff_r;
    len_nxt           = len_r;

    out_valid_nxt     = out_valid_r && !out_ready;
    out_kind_nxt      = out_kind_r;
    out_volume_nxt    = out_volume_r;
    out_position_nxt  = out_position_r;
    out_len_nxt       = out_len_r;
    out_boff_nxt      = out_boff_r;
    out_wr_nxt        = out_wr_r;
    out_last_nxt      = out_last_r;

    div_req.start     = 1'b0;
    div_req.dividend  = in_first_byte;
    div_req.divisor   = bs_eff;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt    = in_opcode;
          first_nxt = in_first_byte;
          count_nxt = in_byte_count;
          if (in_opcode == OP_READ || in_opcode == OP_WRITE) begin
            div_req.start = 1'b1;
            state_nxt     = ST_DIV_BLK;
          end else begin
            state_nxt = ST_ERR;
          end
        end
      end
      ST_DIV_BLK: begin
        // first / block_size done: quotient goes on to be split by volume count
        if (div_rsp.done) begin
          inblock_nxt      = div_rsp.remainder;
          div_req.start    = 1'b1;
          div_req.dividend = div_rsp.quotient;
          div_req.divisor  = DSR_W'(n_eff);
          state_nxt        = ST_DIV_VOL;
        end
      end
      ST_DIV_VOL: begin
        if (div_rsp.done) begin
          fullvol_nxt = div_rsp.remainder[VOL_W-1:0];
          mcand_nxt   = div_rsp.quotient;
          mplier_nxt  = bs_eff;
          acc_nxt     = '0;
          state_nxt   = ST_MUL;
        end
      end
      ST_MUL: begin
        // stripe count times block size, one multiplier bit per cycle
        if (mplier_r == '0) begin
          state_nxt = ST_PREP;
        end else begin
          if (mplier_r[0]) acc_nxt = acc_r + mcand_r;
          mcand_nxt  = {mcand_r[ADDR_W-2:0], 1'b0};
          mplier_nxt = {1'b0, mplier_r[BLK_W-1:1]};
        end
      end
      ST_PREP: begin
        len0_nxt      = len0_calc;
        lim_nxt       = EXTRA_BLOCKS * LIM_W'(bs_eff) + LIM_W'(len0_calc);
        off1_nxt      = acc_r + ADDR_W'(bs_eff);
        offm_nxt      = acc_r + ADDR_W'(inblock_r);
        need_seek_nxt = (expected_next_r != {1'b0, first_r}) || (prev_op_r != op_r[0]);
        state_nxt     = ST_CHECK;
      end
      ST_CHECK: begin
        // count fits in MAX_CHUNKS chunks iff count <= len0 + (MAX_CHUNKS-1)*bs
        if (CMP_W'(count_r) > CMP_W'(lim_r)) begin
          state_nxt = ST_ERR;
        end else begin
          expected_next_nxt = {1'b0, first_r} + (ADDR_W + 1)'(count_r);
          if (need_seek_r && count_r != '0) prev_op_nxt = op_r[0];
          seek_idx_nxt = '0;
          cvol_nxt     = fullvol_r;
          left_nxt     = count_r;
          boff_nxt     = '0;
          len_nxt      = len0_r;
          if (need_seek_r) state_nxt = ST_SEEK;
          else if (count_r != '0) state_nxt = ST_CHUNK;
          else state_nxt = ST_IDLE;
        end
      end
      ST_SEEK: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_kind_nxt   = KIND_SEEK;
          out_volume_nxt = seek_idx_r;
          if (seek_idx_r < fullvol_r) out_position_nxt = off1_r;
          else if (seek_idx_r == fullvol_r) out_position_nxt = offm_r;
          else out_position_nxt = acc_r;
          out_len_nxt    = '0;
          out_boff_nxt   = '0;
          out_wr_nxt     = op_r[0];
          out_last_nxt   = seek_last && (count_r == '0);
          seek_idx_nxt   = seek_idx_r + 1'b1;
          if (seek_last) state_nxt = (count_r != '0) ? ST_CHUNK : ST_IDLE;
        end
      end
      ST_CHUNK: begin
        if (slot_free) begin
          out_valid_nxt    = 1'b1;
          out_kind_nxt     = KIND_XFER;
          out_volume_nxt   = cvol_r;
          out_position_nxt = '0;
          out_len_nxt      = clen;
          out_boff_nxt     = boff_r;
          out_wr_nxt       = op_r[0];
          out_last_nxt     = chunk_last;
          left_nxt         = left_r - COUNT_W'(clen);
          boff_nxt         = boff_r + COUNT_W'(clen);
          len_nxt          = bs_eff;
          cvol_nxt         = ((NVOL_W'(cvol_r) + NVOL_W'(1)) == n_eff) ? '0 : cvol_r + 1'b1;
          if (chunk_last) state_nxt = ST_IDLE;
        end
      end
      ST_ERR: begin
        if (slot_free) begin
          out_valid_nxt    = 1'b1;
          out_kind_nxt     = KIND_ERR;
          out_volume_nxt   = '0;
          out_position_nxt = '0;
          out_len_nxt      = '0;
          out_boff_nxt     = '0;
          out_wr_nxt       = 1'b0;
          out_last_nxt     = 1'b1;
          state_nxt        = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      out_valid_r     <= 1'b0;
      expected_next_r <= '1;
      prev_op_r       <= 1'b0;
      num_volumes_r   <= NVOL_W'(1);
      block_size_r    <= DEFAULT_BLOCK;
    end else begin
      state_r         <= state_nxt;
      out_valid_r     <= out_valid_nxt;
      expected_next_r <= expected_next_nxt;
      prev_op_r       <= prev_op_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_NUM_VOLUMES: num_volumes_r <= cfg_data[NVOL_W-1:0];
          REG_BLOCK_SIZE:  block_size_r  <= cfg_data[BLK_W-1:0];
        endcase
      end
    end
    op_r           <= op_nxt;
    first_r        <= first_nxt;
    count_r        <= count_nxt;
    inblock_r      <= inblock_nxt;
    fullvol_r      <= fullvol_nxt;
    mcand_r        <= mcand_nxt;
    mplier_r       <= mplier_nxt;
    acc_r          <= acc_nxt;
    off1_r         <= off1_nxt;
    offm_r         <= offm_nxt;
    len0_r         <= len0_nxt;
    lim_r          <= lim_nxt;
    need_seek_r    <= need_seek_nxt;
    seek_idx_r     <= seek_idx_nxt;
    cvol_r         <= cvol_nxt;
    left_r         <= left_nxt;
    boff_r         <= boff_nxt;
    len_r          <= len_nxt;
    out_kind_r     <= out_kind_nxt;
    out_volume_r   <= out_volume_nxt;
    out_position_r <= out_position_nxt;
    out_len_r      <= out_len_nxt;
    out_boff_r     <= out_boff_nxt;
    out_wr_r       <= out_wr_nxt;
    out_last_r     <= out_last_nxt;
  end

  // nothing is taken while reset is held
  assign in_ready          = rst_n && (state_r == ST_IDLE);
  assign cfg_ready         = rst_n;
  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_volume        = out_volume_r;
  assign out_position      = out_position_r;
  assign out_chunk_length  = out_len_r;
  assign out_buffer_offset = out_boff_r;
  assign out_is_write      = out_wr_r;
  assign out_last          = out_last_r;

endmodule

[src/scp_checker.sv]
// ----------------------------------------------------------------------------
// scp_checker
// Port-level checks for the stripe chunk planner, bound to the top level.
// ----------------------------------------------------------------------------
module scp_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic [scp_pkg::KIND_W-1:0]       out_kind,
  input  logic [scp_pkg::VOL_W-1:0]        out_volume,
  input  logic [scp_pkg::ADDR_W-1:0]       out_position,
  input  logic [scp_pkg::BLK_W-1:0]        out_chunk_length,
  input  logic [scp_pkg::COUNT_W-1:0]      out_buffer_offset,
  input  logic                             out_is_write,
  input  logic                             out_last
);
  import scp_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_volume)
      && $stable(out_position) && $stable(out_chunk_length)
      && $stable(out_buffer_offset) && $stable(out_is_write) && $stable(out_last))
    else $error("result changed while stalled");

  // the planner works on one request at a time
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after accepting a request");

  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_ERR |-> out_last && out_volume == '0
      && out_chunk_length == '0 && !out_is_write)
    else $error("malformed error result");

  a_seek_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_SEEK |-> out_chunk_length == '0 && out_buffer_offset == '0)
    else $error("seek carries transfer fields");

  a_xfer_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_XFER |-> out_chunk_length != '0 && out_position == '0)
    else $error("empty or positioned transfer chunk");

endmodule

bind stripe_chunk_planner scp_checker u_scp_checker (.*);
